// ----- rtl/mm4_pkg.sv -----
// Shared types and constants of the fixed-point matrix multiplier.
`default_nettype none
package mm4_pkg;

  localparam int unsigned ROW_W = 2;
  localparam int unsigned COL_W = 2;
  localparam int unsigned VAL_W = 32;

  // Request payload, lowest field first: row, col, value, write enable, start.
  typedef struct packed {
    logic             start;
    logic             wr_en;
    logic [VAL_W-1:0] value;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } in_data_t;

  // Result payload, lowest field first: row, col, value.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } out_data_t;

  localparam int unsigned IN_FIELDS_W  = $bits(in_data_t);
  localparam int unsigned OUT_FIELDS_W = $bits(out_data_t);
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned START_BIT    = IN_FIELDS_W - 1;

  // Request target carried in tuser.
  localparam logic SEL_LEFT  = 1'b0;
  localparam logic SEL_RIGHT = 1'b1;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

endpackage
`default_nettype wire

// ----- rtl/matrix_multiply_4x4.sv -----
// Top level of the fixed-point square matrix multiplier.
//
// Usage: requests enter on the s_axis channel. Each request may write one
// element (row, col, value) of the left (tuser = 0) or right (tuser = 1)
// matrix, and with the start flag set it then emits the whole product on the
// m_axis channel, DIM*DIM results in row-major order, tlast on the final one.
// Write-only requests are taken one per cycle. After a start request the
// block drops s_axis_tready until the final result sits in the output
// register. Results are made one at a time: DIM reads feeding one
// shared 32x32 multiplier and one accumulator, then the read, multiply
// and accumulate stages drain, and last the result is shifted, saturated
// and loaded into the output register.
// Values are signed fixed point with FRAC_BITS fraction bits; sums are kept
// exact, shifted right arithmetically and saturated to 32 bits.
// Reset clears both matrices to zero (per-entry valid flags) and empties the
// output register. When the receiver stalls, the result holds in the output
// register and the sequencer waits before loading the next one.
`default_nettype none
module matrix_multiply_4x4 #(
  parameter int unsigned DIM       = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: row[1:0], col[3:2], value[35:4], write_enable[36], start_req[37]
  input  wire logic [mm4_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // tuser: req_type[0]
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: out_row[1:0], out_col[3:2], out_value[35:4]
  output logic [mm4_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast
);

  import mm4_pkg::*;

  localparam int unsigned CELLS  = DIM * DIM;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned IDX_W  = $clog2(DIM);
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned ACC_W  = PROD_W + IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINAL
  } state_e;

  state_e state_q;

  // Request decode and element writes.
  in_data_t          req;
  logic              req_fire;
  logic              wr_ok;
  logic              wr_left;
  logic              wr_right;
  logic [ADDR_W-1:0] wr_addr;

  assign req      = in_data_t'(s_axis_tdata[IN_FIELDS_W-1:0]);
  assign req_fire = s_axis_tvalid && s_axis_tready;
  assign wr_ok    = req_fire && req.wr_en &&
                    (32'(req.row) < 32'(DIM)) && (32'(req.col) < 32'(DIM));
  assign wr_left  = wr_ok && (s_axis_tuser == SEL_LEFT);
  assign wr_right = wr_ok && (s_axis_tuser == SEL_RIGHT);
  assign wr_addr  = ADDR_W'(req.row) * ADDR_W'(DIM) + ADDR_W'(req.col);

  // Entries never written read as zero.
  logic [CELLS-1:0] left_vld_q;
  logic [CELLS-1:0] right_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_vld_q  <= '0;
      right_vld_q <= '0;
    end else begin
      if (wr_left) begin
        left_vld_q[wr_addr] <= 1'b1;
      end
      if (wr_right) begin
        right_vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  // Sequencer counters: product row, product column, dot-product term.
  logic [IDX_W-1:0]  r_q;
  logic [IDX_W-1:0]  c_q;
  logic [IDX_W-1:0]  e_q;
  logic              issue;
  logic [ADDR_W-1:0] left_raddr;
  logic [ADDR_W-1:0] right_raddr;

  assign issue       = (state_q == ST_ISSUE);
  assign left_raddr  = ADDR_W'(r_q) * ADDR_W'(DIM) + ADDR_W'(e_q);
  assign right_raddr = ADDR_W'(e_q) * ADDR_W'(DIM) + ADDR_W'(c_q);

  logic [VAL_W-1:0] left_rdata;
  logic [VAL_W-1:0] right_rdata;

  mm4_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CELLS)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (wr_left),
    .waddr_i (wr_addr),
    .wdata_i (req.value),
    .re_i    (issue),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  mm4_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CELLS)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (wr_right),
    .waddr_i (wr_addr),
    .wdata_i (req.value),
    .re_i    (issue),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  // Read stage tags, product stage, accumulator.
  logic                     rd_vld_q, rd_first_q, rd_last_q;
  logic                     left_ok_q, right_ok_q;
  logic                     mul_vld_q, mul_first_q, mul_last_q;
  logic                     acc_done_q;
  logic signed [VAL_W-1:0]  left_op;
  logic signed [VAL_W-1:0]  right_op;
  logic signed [PROD_W-1:0] mul_q;
  logic signed [ACC_W-1:0]  mul_ext;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;

  assign left_op  = left_ok_q  ? $signed(left_rdata)  : '0;
  assign right_op = right_ok_q ? $signed(right_rdata) : '0;
  assign mul_ext  = ACC_W'(mul_q);
  assign acc_d    = mul_first_q ? mul_ext : acc_q + mul_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      mul_vld_q   <= 1'b0;
      mul_first_q <= 1'b0;
      mul_last_q  <= 1'b0;
      acc_done_q  <= 1'b0;
    end else begin
      rd_vld_q    <= issue;
      rd_first_q  <= issue && (e_q == '0);
      rd_last_q   <= issue && (e_q == IDX_LAST);
      mul_vld_q   <= rd_vld_q;
      mul_first_q <= rd_first_q;
      mul_last_q  <= rd_last_q;
      acc_done_q  <= mul_vld_q && mul_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      left_ok_q  <= left_vld_q[left_raddr];
      right_ok_q <= right_vld_q[right_raddr];
    end
    if (rd_vld_q) begin
      mul_q <= left_op * right_op;
    end
    if (mul_vld_q) begin
      acc_q <= acc_d;
    end
  end

  // Drop the fraction bits, then clamp to the 32-bit range.
  logic signed [ACC_W-1:0] acc_shifted;
  logic [ACC_W-VAL_W:0]    acc_high;
  logic                    acc_fits;
  logic [VAL_W-1:0]        sat_value;

  assign acc_shifted = acc_q >>> FRAC_BITS;
  assign acc_high    = acc_shifted[ACC_W-1:VAL_W-1];
  assign acc_fits    = (&acc_high) || !(|acc_high);
  assign sat_value   = acc_fits ? acc_shifted[VAL_W-1:0] :
                       (acc_shifted[ACC_W-1] ? VAL_MIN : VAL_MAX);

  // Sequencer and output register.
  out_data_t out_q;
  logic      out_vld_q;
  logic      out_last_q;
  logic      out_free;
  logic      load_out;
  logic      elem_last;

  assign out_free  = !out_vld_q || m_axis_tready;
  assign load_out  = (state_q == ST_FINAL) && out_free;
  assign elem_last = (r_q == IDX_LAST) && (c_q == IDX_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      r_q        <= '0;
      c_q        <= '0;
      e_q        <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      out_q      <= '0;
    end else begin
      // Load a new result, or drop the one the receiver just took.
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_fire && req.start) begin
            r_q     <= '0;
            c_q     <= '0;
            e_q     <= '0;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (e_q == IDX_LAST) begin
            e_q     <= '0;
            state_q <= ST_DRAIN;
          end else begin
            e_q <= e_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (acc_done_q) begin
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            out_q.row   <= ROW_W'(r_q);
            out_q.col   <= COL_W'(c_q);
            out_q.value <= sat_value;
            out_last_q  <= elem_last;
            if (elem_last) begin
              state_q <= ST_IDLE;
            end else begin
              // Advance row-major to the next product element.
              if (c_q == IDX_LAST) begin
                c_q <= '0;
                r_q <= r_q + 1'b1;
              end else begin
                c_q <= c_q + 1'b1;
              end
              state_q <= ST_ISSUE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// ----- rtl/mm4_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mm4_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mm4_chk.sv -----
// Port-level checker of the matrix multiplier and its bind to the top level.
`default_nettype none
module mm4_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [mm4_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [mm4_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                            m_axis_tlast
);

  import mm4_pkg::*;

  logic req_fire;
  assign req_fire = s_axis_tvalid && s_axis_tready;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // No request is taken while a product is still being emitted.
  a_busy_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken in the middle of a product");

  // A start request makes the block busy.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && s_axis_tdata[START_BIT] |=> !s_axis_tready)
    else $error("still ready after a start request");

  // Element writes alone keep the block ready.
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && !s_axis_tdata[START_BIT] |=> s_axis_tready)
    else $error("ready dropped after a write-only request");

endmodule

bind matrix_multiply_4x4 mm4_chk u_mm4_chk (.*);
`default_nettype wire

// ----- dv/matrix_multiply_4x4_test.sv -----
// Self-checking testbench for the 4x4 fixed-point matrix multiplier.
module matrix_multiply_4x4_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mm4_pkg::*;

  localparam int DIM         = 4;
  localparam int FRAC        = 16;
  localparam int RAND_ITEMS  = 225;
  localparam int CALM_TAIL   = 40;     // requests at the end sent with no idling
  localparam int WATCH_LIMIT = 2000;   // cycles with no handshake at all
  localparam int SETTLE      = 40;     // cycles to watch for stray results at the end
  localparam int SHOW_MAX    = 10;

  // One request as queued for the driver.
  typedef struct {
    logic     sel;          // SEL_LEFT or SEL_RIGHT
    in_data_t body;
    bit       drain_first;  // hold until every product element has arrived
  } mm_req_t;

  // One product element as it should leave the block.
  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
  } mm_elem_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: row[1:0], col[3:2], value[35:4], write_enable[36], start_req[37]
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // tuser: req_type[0]
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: out_row[1:0], out_col[3:2], out_value[35:4]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  matrix_multiply_4x4 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Shadow copies of both operand matrices, row-major.
  logic signed [VAL_W-1:0] left_mat  [DIM][DIM];
  logic signed [VAL_W-1:0] right_mat [DIM][DIM];

  mm_req_t  req_q[$];       // requests not yet driven
  mm_elem_t product_q[$];   // product elements still owed by the block

  mm_req_t  cur_req;
  int       src_gap  = 0;
  int       sink_gap = 0;
  int       idle_cycles = 0;
  int       mismatches = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Dot product of a left row and a right column: sum exactly, shift
  // arithmetically (floor), then clamp to 32 bits.
  function automatic logic [VAL_W-1:0] dot_q16(int r, int c);
    logic signed [127:0] acc;
    logic signed [63:0]  prod;
    acc = '0;
    for (int e = 0; e < DIM; e++) begin
      prod = 64'(left_mat[r][e]) * 64'(right_mat[e][c]);
      acc  = acc + prod;
    end
    acc = acc >>> FRAC;
    if (acc > 128'sd2147483647) return VAL_MAX;
    if (acc < -128'sd2147483648) return VAL_MIN;
    return acc[VAL_W-1:0];
  endfunction

  // Update the shadow matrices for an accepted request and queue the
  // product it triggers, if any. The write lands before the product.
  task automatic apply_request(mm_req_t q);
    mm_elem_t el;
    if (q.body.wr_en && q.body.row < DIM && q.body.col < DIM) begin
      if (q.sel == SEL_RIGHT) right_mat[q.body.row][q.body.col] = q.body.value;
      else                    left_mat[q.body.row][q.body.col]  = q.body.value;
    end
    if (q.body.start) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          el.row   = ROW_W'(r);
          el.col   = COL_W'(c);
          el.value = dot_q16(r, c);
          el.last  = (r == DIM - 1) && (c == DIM - 1);
          product_q.push_back(el);
        end
      end
    end
  endtask

  function automatic void push_req(logic sel, int row, int col, logic [VAL_W-1:0] value,
                                   logic wr_en, logic start, bit drain_first = 1'b0);
    mm_req_t q;
    q.sel        = sel;
    q.body.row   = ROW_W'(row);
    q.body.col   = COL_W'(col);
    q.body.value = value;
    q.body.wr_en = wr_en;
    q.body.start = start;
    q.drain_first = drain_first;
    req_q.push_back(q);
  endfunction

  // Element values: mostly small Q16.16 numbers, plus extremes and raw bits.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return VAL_MAX;
      2:       return VAL_MIN;
      5:       return $urandom_range(0, 7) - 32'd4;               // tiny, tests flooring
      default: return $urandom_range(0, 32'h5FFFF) - 32'h30000;  // about +-3.0
    endcase
  endfunction

  // Driver: present the head of req_q, hold it until taken, idle in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [IN_TDATA_W-1:0] word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(cur_req);
        if (req_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
          src_gap = $urandom_range(1, 16);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() == 0 ||
                     (req_q[0].drain_first && product_q.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_req = req_q.pop_front();
          word = '0;
          word[IN_FIELDS_W-1:0] = cur_req.body;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= word;
          s_axis_tuser  <= cur_req.sel;
        end
      end
    end
  end

  // Monitor: check each product element against the oldest one owed,
  // stall the result channel in bursts, and watch for a hung block.
  always @(posedge clk_i or negedge rst_ni) begin
    out_data_t got;
    mm_elem_t  want;
    logic      rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
      idle_cycles = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OUT_FIELDS_W-1:0];
        if (product_q.size() == 0) begin
          if (mismatches < SHOW_MAX)
            $display("%0t: unexpected product element row %0d col %0d value %h last %b",
                     $realtime, got.row, got.col, got.value, m_axis_tlast);
          mismatches++;
        end else begin
          want = product_q.pop_front();
          if (got.row !== want.row || got.col !== want.col ||
              got.value !== want.value || m_axis_tlast !== want.last) begin
            if (mismatches < SHOW_MAX) begin
              $display("%0t: product mismatch: expected row %0d col %0d value %h last %b,",
                       $realtime, want.row, want.col, want.value, want.last);
              $display("  got row %0d col %0d value %h last %b",
                       got.row, got.col, got.value, m_axis_tlast);
            end
            mismatches++;
          end
        end
      end

      if (sink_gap > 0) begin
        sink_gap--;
        rdy = 1'b0;
      end else if (req_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 15);  // this cycle is the first of the burst
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;

      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, WATCH_LIMIT);
        $display("matrix_multiply_4x4_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int       counted;
    int       kind;
    logic     sel;
    logic     we;

    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        left_mat[r][c]  = '0;
        right_mat[r][c] = '0;
      end
    end

    // Directed part.
    // Product straight after reset: both matrices are zero.
    push_req(SEL_LEFT, 0, 0, '0, 1'b0, 1'b1, 1'b1);
    // Largest positive squared: clamp high; write and start in one request.
    push_req(SEL_LEFT, 0, 0, VAL_MAX, 1'b1, 1'b0);
    push_req(SEL_RIGHT, 0, 0, VAL_MAX, 1'b1, 1'b1);
    // Largest positive times most negative: clamp low. Hold this request
    // until the previous product has fully arrived.
    push_req(SEL_RIGHT, 0, 0, VAL_MIN, 1'b1, 1'b1, 1'b1);
    // Most negative squared: clamp high.
    push_req(SEL_LEFT, 0, 0, VAL_MIN, 1'b1, 1'b1);
    // Tiny negative product floors to -1 LSB in the far corner.
    push_req(SEL_LEFT, 3, 3, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_req(SEL_RIGHT, 3, 3, 32'h0000_0001, 1'b1, 1'b1);
    // Plain fractional arithmetic: 1.0 * x and 2.5 * -1.0.
    push_req(SEL_RIGHT, 0, 0, 32'h0001_0000, 1'b1, 1'b0);
    push_req(SEL_LEFT, 0, 1, 32'h0002_8000, 1'b1, 1'b0);
    push_req(SEL_RIGHT, 1, 0, 32'hFFFF_0000, 1'b1, 1'b1);
    // Disabled write with start: the element must stay untouched.
    push_req(SEL_LEFT, 2, 1, 32'h1234_5678, 1'b0, 1'b1);
    // Disabled write without start: no output at all.
    push_req(SEL_RIGHT, 3, 2, 32'hFFFF_FFFF, 1'b0, 1'b0);
    // Full row times full column of maxima: large sum, clamp high.
    for (int i = 0; i < DIM; i++) begin
      push_req(SEL_LEFT, 3, i, VAL_MAX, 1'b1, 1'b0);
      push_req(SEL_RIGHT, i, 3, VAL_MAX, 1'b1, 1'b0);
    end
    push_req(SEL_LEFT, 1, 2, pick_value(), 1'b1, 1'b1);

    // Random part: runs of element writes with an occasional product request,
    // plus some ignored requests as noise.
    counted = 0;
    while (counted < RAND_ITEMS) begin
      kind = $urandom_range(0, 19);
      sel  = 1'($urandom_range(0, 1));
      if (kind == 0) begin
        push_req(sel, $urandom_range(0, 3), $urandom_range(0, 3), $urandom(), 1'b0, 1'b0);
      end else begin
        we = (kind <= 2) ? 1'($urandom_range(0, 1)) : 1'b1;
        push_req(sel, $urandom_range(0, 3), $urandom_range(0, 3), pick_value(), we,
                 kind <= 2, counted == RAND_ITEMS / 2);
        counted++;
      end
    end
    push_req(SEL_RIGHT, 2, 2, pick_value(), 1'b1, 1'b1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to go out and every element owed to arrive.
    while (req_q.size() != 0 || s_axis_tvalid || product_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (mismatches == 0 && product_q.size() == 0) begin
      $display("matrix_multiply_4x4_test: PASS");
    end else begin
      $display("matrix_multiply_4x4_test: FAIL");
    end
    $finish;
  end

endmodule
